// File: rtl/phash_dct_32x32_low8x8_core_assert.svh
`ifndef PHASH_DCT_32X32_LOW8X8_CORE_ASSERT_SVH
`define PHASH_DCT_32X32_LOW8X8_CORE_ASSERT_SVH

// same-cycle implication
`define PHD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("phd assertion failed");

// next-cycle implication
`define PHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("phd assertion failed");

`endif

// File: rtl/phd_pkg.sv
`default_nettype none
package phd_pkg;

    localparam int IMAGE_SIZE = 32;
    localparam int OUT_SIZE   = 8;
    localparam int PIX_W      = 8;
    localparam int COS_W      = 16;
    localparam int RP_W       = 28;
    localparam int PROD_W     = RP_W + COS_W;
    localparam int ACC_W      = 50;
    localparam int COEF_W     = 19;
    localparam int AC_W       = 26;
    localparam int ACM_W      = 25;
    localparam int RND_SHIFT  = 28;
    localparam int IDX_W      = 6;
    localparam logic [IDX_W-1:0] LAST_IDX = 6'd63;
    localparam logic [COEF_W-2:0] COEF_MAX = 18'h3FFFF;
    localparam logic signed [AC_W-1:0] AC_MAX = 26'sd16777215;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW,
        ST_ROW_WAIT,
        ST_COL,
        ST_COL_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       pix_we;
        logic [9:0] pix_addr;
        logic       mac_en;
        logic       col_mode;
        logic       first;
        logic       last;
        logic       final_step;
        logic [7:0] rp_addr;
        logic [4:0] cos_x;
        logic [2:0] cos_y;
        logic       out_load;
        logic [IDX_W-1:0] coef_index;
    } cmd_t;

    typedef struct packed {
        logic row_done;
        logic coef_ready;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic       valid;
        logic       col_mode;
        logic       first;
        logic       last;
        logic       final_step;
        logic [7:0] waddr;
    } ctl_t;

    // cos(pi*(2x+1)*y/64) in signed q1.14
    function automatic logic signed [COS_W-1:0] cos_q14(input logic [4:0] x,
                                                        input logic [2:0] y);
        logic [8:0] k;
        logic [6:0] a;
        logic       neg;
        logic [14:0] mag;
        k   = 9'({x, 1'b1}) * 9'(y);
        a   = k[6:0];
        neg = 1'b0;
        if (a > 7'd64) a = 7'd0 - a;
        if (a > 7'd32) begin
            a   = 7'd64 - a;
            neg = 1'b1;
        end
        unique case (a[5:0])
            6'd0:  mag = 15'd16384;
            6'd1:  mag = 15'd16364;
            6'd2:  mag = 15'd16305;
            6'd3:  mag = 15'd16207;
            6'd4:  mag = 15'd16069;
            6'd5:  mag = 15'd15893;
            6'd6:  mag = 15'd15679;
            6'd7:  mag = 15'd15426;
            6'd8:  mag = 15'd15137;
            6'd9:  mag = 15'd14811;
            6'd10: mag = 15'd14449;
            6'd11: mag = 15'd14053;
            6'd12: mag = 15'd13623;
            6'd13: mag = 15'd13160;
            6'd14: mag = 15'd12665;
            6'd15: mag = 15'd12140;
            6'd16: mag = 15'd11585;
            6'd17: mag = 15'd11003;
            6'd18: mag = 15'd10394;
            6'd19: mag = 15'd9760;
            6'd20: mag = 15'd9102;
            6'd21: mag = 15'd8423;
            6'd22: mag = 15'd7723;
            6'd23: mag = 15'd7005;
            6'd24: mag = 15'd6270;
            6'd25: mag = 15'd5520;
            6'd26: mag = 15'd4756;
            6'd27: mag = 15'd3981;
            6'd28: mag = 15'd3196;
            6'd29: mag = 15'd2404;
            6'd30: mag = 15'd1606;
            6'd31: mag = 15'd804;
            default: mag = 15'd0;
        endcase
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage
`default_nettype wire

// File: rtl/phd_ctrl.sv
`default_nettype none
module phd_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  phd_pkg::status_t status,
    output phd_pkg::cmd_t    cmd
);
    import phd_pkg::*;

    state_t      state_reg, state_next;
    logic [12:0] cnt_reg, cnt_next;
    logic [5:0]  k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (cnt_reg[9:0] == 10'h3FF) begin
                        cnt_next   = '0;
                        state_next = ST_ROW;
                    end else begin
                        cnt_next = cnt_reg + 13'd1;
                    end
                end
            end
            ST_ROW: begin
                cnt_next = cnt_reg + 13'd1;
                if (cnt_reg == 13'h1FFF) state_next = ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
                if (status.row_done) state_next = ST_COL;
            end
            ST_COL: begin
                if (cnt_reg[4:0] == 5'd31) begin
                    cnt_next   = '0;
                    state_next = ST_COL_WAIT;
                end else begin
                    cnt_next = cnt_reg + 13'd1;
                end
            end
            ST_COL_WAIT: begin
                if (status.coef_ready) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    k_next     = k_reg + 6'd1;
                    state_next = (k_reg == LAST_IDX) ? ST_LOAD : ST_COL;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == ST_LOAD);
        cmd            = '0;
        cmd.pix_addr   = cnt_reg[9:0];
        cmd.coef_index = k_reg;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.pix_we = s_valid;
            end
            ST_ROW: begin
                cmd.mac_en     = 1'b1;
                cmd.pix_addr   = {cnt_reg[12:8], cnt_reg[4:0]};
                cmd.cos_x      = cnt_reg[4:0];
                cmd.cos_y      = cnt_reg[7:5];
                cmd.rp_addr    = cnt_reg[12:5];
                cmd.first      = (cnt_reg[4:0] == 5'd0);
                cmd.last       = (cnt_reg[4:0] == 5'd31);
                cmd.final_step = (cnt_reg == 13'h1FFF);
            end
            ST_COL: begin
                cmd.mac_en   = 1'b1;
                cmd.col_mode = 1'b1;
                cmd.rp_addr  = {cnt_reg[4:0], k_reg[2:0]};
                cmd.cos_x    = cnt_reg[4:0];
                cmd.cos_y    = k_reg[5:3];
                cmd.first    = (cnt_reg[4:0] == 5'd0);
                cmd.last     = (cnt_reg[4:0] == 5'd31);
            end
            ST_EMIT: begin
                cmd.out_load = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/phd_datapath.sv
`default_nettype none
module phd_datapath (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  phd_pkg::cmd_t                     cmd,
    output phd_pkg::status_t                  status,
    input  wire  [phd_pkg::PIX_W-1:0]         s_pixel,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [phd_pkg::IDX_W-1:0]         m_coef_index,
    output logic signed [phd_pkg::COEF_W-1:0] m_coefficient,
    output logic signed [phd_pkg::ACM_W-1:0]  m_ac_mean_q16,
    output logic                              m_last
);
    import phd_pkg::*;

    logic [PIX_W-1:0]        pix_mem [1024];
    logic signed [RP_W-1:0]  rp_mem  [256];

    logic [PIX_W-1:0]        pix_q_reg;
    logic signed [RP_W-1:0]  rp_q_reg;
    logic signed [COS_W-1:0] cos_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic signed [COEF_W-1:0] coef_hold_reg;
    ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;

    logic                     m_valid_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [ACM_W-1:0]  acm_reg;
    logic                     last_reg;
    logic signed [AC_W-1:0]   ac_reg, ac_next;

    logic signed [RP_W-1:0]   op_a;
    logic [ACC_W-RND_SHIFT-1:0] rnd;
    logic [COEF_W-2:0]        rnd_sat;
    logic signed [AC_W-1:0]   ac_sum;

    always_ff @(posedge aclk) begin
        if (cmd.pix_we) pix_mem[cmd.pix_addr] <= s_pixel;
        pix_q_reg <= pix_mem[cmd.pix_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl3_reg.valid && ctl3_reg.last && !ctl3_reg.col_mode)
            rp_mem[ctl3_reg.waddr] <= acc_reg[RP_W-1:0];
        rp_q_reg <= rp_mem[cmd.rp_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end else begin
            ctl1_reg.valid      <= cmd.mac_en;
            ctl1_reg.col_mode   <= cmd.col_mode;
            ctl1_reg.first      <= cmd.first;
            ctl1_reg.last       <= cmd.last;
            ctl1_reg.final_step <= cmd.final_step;
            ctl1_reg.waddr      <= cmd.rp_addr;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    assign op_a = ctl1_reg.col_mode ? rp_q_reg : $signed(RP_W'({1'b0, pix_q_reg}));
    assign rnd  = (ACC_W-RND_SHIFT)'((mag_reg + (ACC_W'(1) << (RND_SHIFT - 1)))
                                     >> RND_SHIFT);
    assign rnd_sat = (rnd > (ACC_W-RND_SHIFT)'(COEF_MAX)) ? COEF_MAX : rnd[COEF_W-2:0];

    always_ff @(posedge aclk) begin
        cos_q_reg <= cos_q14(cmd.cos_x, cmd.cos_y);
        prod_reg  <= op_a * cos_q_reg;
        if (ctl2_reg.valid)
            acc_reg <= ctl2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        neg_reg <= acc_reg[ACC_W-1];
        mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        if (ctl4_reg.valid && ctl4_reg.last)
            coef_hold_reg <= neg_reg ? -$signed({1'b0, rnd_sat}) : $signed({1'b0, rnd_sat});
    end

    assign ac_sum = (cmd.coef_index == '0) ? '0 : ac_reg + AC_W'(coef_hold_reg);
    always_comb begin
        if (ac_sum > AC_MAX)       ac_next = AC_MAX;
        else if (ac_sum < -AC_MAX) ac_next = -AC_MAX;
        else                       ac_next = ac_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ac_reg      <= '0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
            ac_reg      <= ac_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            idx_reg  <= cmd.coef_index;
            coef_reg <= coef_hold_reg;
            last_reg <= (cmd.coef_index == LAST_IDX);
            acm_reg  <= (cmd.coef_index == LAST_IDX) ? ac_next[ACM_W-1:0] : '0;
        end
    end

    assign status.row_done   = ctl3_reg.valid && ctl3_reg.last && ctl3_reg.final_step
                               && !ctl3_reg.col_mode;
    assign status.coef_ready = ctl5_reg.valid && ctl5_reg.last && ctl5_reg.col_mode;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_coef_index  = idx_reg;
    assign m_coefficient = coef_reg;
    assign m_ac_mean_q16 = acm_reg;
    assign m_last        = last_reg;

endmodule
`default_nettype wire

// File: rtl/phash_dct_32x32_low8x8_core.sv
// operation: the row pass runs on one multiplier after the last pixel transfer, then
// each coefficient is a column sum of 32 products, emitted while the output is free;
// the next frame's pixels are accepted only after the last coefficient is loaded
// synchronous active-low reset returns to pixel loading with empty output
`default_nettype none
`include "phash_dct_32x32_low8x8_core_assert.svh"
module phash_dct_32x32_low8x8_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [phd_pkg::PIX_W-1:0]         s_pixel,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [phd_pkg::IDX_W-1:0]         m_coef_index,
    output logic signed [phd_pkg::COEF_W-1:0] m_coefficient,
    output logic signed [phd_pkg::ACM_W-1:0]  m_ac_mean_q16,
    output logic                              m_last
);
    import phd_pkg::*;

    cmd_t    cmd;
    status_t status;

    phd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    phd_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_pixel       (s_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coef_index  (m_coef_index),
        .m_coefficient (m_coefficient),
        .m_ac_mean_q16 (m_ac_mean_q16),
        .m_last        (m_last)
    );

    `PHD_ASSERT_NOW(a_last_idx, m_valid, m_last == (m_coef_index == LAST_IDX))
    `PHD_ASSERT_NOW(a_ac_zero, m_valid && !m_last, m_ac_mean_q16 == '0)
    `PHD_ASSERT_NEXT(a_load_valid, cmd.out_load, m_valid)

endmodule
`default_nettype wire

// File: tb/sv/phash_dct_32x32_low8x8_core_test.sv
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic [phd_pkg::IDX_W-1:0]         idx;
    logic signed [phd_pkg::COEF_W-1:0] coef;
    logic signed [phd_pkg::ACM_W-1:0]  acm;
    logic                              last;
} coef_item_t;

class dct_scoreboard;
    localparam int N = 32;
    localparam int M = 8;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    int          cos_tab [N][M];
    logic [7:0]  image [N*N];
    int          pix_cnt;
    coef_item_t  coef_q [$];
    int          errors;
    int          frames;
    int          results;

    function new();
        for (int x = 0; x < N; x++)
            for (int y = 0; y < M; y++)
                cos_tab[x][y] = cos_fix((2 * x + 1) * y);
        pix_cnt = 0;
        errors  = 0;
        frames  = 0;
        results = 0;
    endfunction

    function int cos_fix(input int k);
        int                a;
        bit                neg;
        longint unsigned   theta, t2, term, mag;
        longint            sum;
        a   = k % (4 * N);
        neg = 0;
        if (a > 2 * N) a = 4 * N - a;
        if (a > N) begin
            a   = 2 * N - a;
            neg = 1;
        end
        theta = (PI_Q30 * longint'(a)) / (2 * N);
        t2    = (theta * theta) >> 30;
        term  = 64'd1 << 30;
        sum   = longint'(term);
        for (int i = 1; i <= 8; i++) begin
            term = ((term * t2) >> 30) / longint'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        mag = (longint'(sum) + (64'd1 << 15)) >> 16;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    function void transform_frame();
        longint     rows [N][M];
        longint     acc, ac_sum, q;
        longint unsigned magn;
        bit         neg;
        coef_item_t it;
        for (int i = 0; i < N; i++)
            for (int v = 0; v < M; v++) begin
                acc = 0;
                for (int j = 0; j < N; j++)
                    acc += longint'(image[i * N + j]) * longint'(cos_tab[j][v]);
                rows[i][v] = acc;
            end
        ac_sum = 0;
        for (int u = 0; u < M; u++)
            for (int v = 0; v < M; v++) begin
                acc = 0;
                for (int i = 0; i < N; i++)
                    acc += longint'(cos_tab[i][u]) * rows[i][v];
                neg  = acc < 0;
                magn = neg ? longint'(-acc) : longint'(acc);
                q    = longint'((magn + (64'd1 << 27)) >> 28);
                if (q > 262143) q = 262143;
                if (neg) q = -q;
                if (u * M + v != 0) begin
                    ac_sum += q;
                    if (ac_sum > 16777215) ac_sum = 16777215;
                    if (ac_sum < -16777215) ac_sum = -16777215;
                end
                it.idx  = 6'(u * M + v);
                it.coef = 19'(q);
                it.last = (u * M + v == M * M - 1);
                it.acm  = it.last ? 25'(ac_sum) : '0;
                coef_q.push_back(it);
            end
        frames++;
    endfunction

    function void note_pixel(input logic [7:0] p);
        image[pix_cnt] = p;
        pix_cnt++;
        if (pix_cnt == N * N) begin
            pix_cnt = 0;
            transform_frame();
        end
    endfunction

    function void check_coef(input logic [5:0] idx, input logic signed [18:0] coef,
                             input logic signed [24:0] acm, input logic last);
        coef_item_t e;
        results++;
        if (coef_q.size() == 0) begin
            $error("unexpected coefficient transfer, index %0d", idx);
            errors++;
            return;
        end
        e = coef_q.pop_front();
        if (idx !== e.idx) begin
            $error("coef_index: expected %0d, got %0d", e.idx, idx);
            errors++;
        end
        if (coef !== e.coef) begin
            $error("coefficient: expected %0d, got %0d", e.coef, coef);
            errors++;
        end
        if (acm !== e.acm) begin
            $error("ac_mean_q16: expected %0d, got %0d", e.acm, acm);
            errors++;
        end
        if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last);
            errors++;
        end
    endfunction
endclass

module phash_dct_32x32_low8x8_core_test;
    localparam int WATCHDOG_LIMIT = 60000;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [phd_pkg::PIX_W-1:0]         s_pixel;
    logic                              m_valid;
    logic                              m_ready;
    logic [phd_pkg::IDX_W-1:0]         m_coef_index;
    logic signed [phd_pkg::COEF_W-1:0] m_coefficient;
    logic signed [phd_pkg::ACM_W-1:0]  m_ac_mean_q16;
    logic                              m_last;

    dct_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cnt;

    phash_dct_32x32_low8x8_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coef_index  (m_coef_index),
        .m_coefficient (m_coefficient),
        .m_ac_mean_q16 (m_ac_mean_q16),
        .m_last        (m_last)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
            if (s_valid && s_ready) sb.note_pixel(s_pixel);
            if (m_valid && m_ready)
                sb.check_coef(m_coef_index, m_coefficient, m_ac_mean_q16, m_last);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("phash_dct_32x32_low8x8_core: mismatch");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] p);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.coef_q.size() != 0) @(posedge aclk);
    endtask

    // style 0 random, 1 extremes only, 2 all white, 3 checkerboard
    task automatic send_frame(input int style, input int first_idx, input bit mid_pause);
        logic [7:0] p;
        for (int n = first_idx; n < 1024; n++) begin
            case (style)
                0: p = 8'($urandom_range(255));
                1: p = $urandom_range(1) ? 8'hFF : 8'h00;
                2: p = 8'hFF;
                default: p = (((n >> 5) ^ n) & 1) ? 8'hFF : 8'h00;
            endcase
            if (mid_pause && n == 517) drain_results();
            send_pixel(p);
        end
    endtask

    initial begin
        logic [7:0] directed [25];
        sb          = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_pixel     = '0;
        m_ready     = 1'b0;
        tx_idle_pct = 19;
        rx_idle_pct = 84;
        directed = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h00, 8'hFF,
                     8'h0F, 8'hF0, 8'h33, 8'hCC, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h02, 8'h40,
                     8'h04, 8'h20, 8'h08, 8'h10, 8'hFF};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed patterns first, then the rest of the frame at random
        foreach (directed[i]) send_pixel(directed[i]);
        send_frame(0, 25, 1'b0);
        send_frame(2, 0, 1'b1);

        drain_results();
        tx_idle_pct = 84;
        rx_idle_pct = 19;
        send_frame(0, 0, 1'b0);
        send_frame(3, 0, 1'b0);

        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_frame(1, 0, 1'b0);
        send_frame(0, 0, 1'b0);

        drain_results();
        repeat (200) @(posedge aclk);

        $display("%0d frames (random, white, checkerboard, extremes), %0d coefficients checked",
                 sb.frames, sb.results);
        $display("idle mixes: light sender/heavy receiver, the reverse, and none");
        if (sb.errors == 0 && sb.pix_cnt == 0 && sb.coef_q.size() == 0)
            $display("phash_dct_32x32_low8x8_core: match");
        else
            $display("phash_dct_32x32_low8x8_core: mismatch");
        $finish;
    end
endmodule

`default_nettype wire

// File: phash_dct_32x32_low8x8_core.f
+incdir+rtl
rtl/phd_pkg.sv
rtl/phd_ctrl.sv
rtl/phd_datapath.sv
rtl/phash_dct_32x32_low8x8_core.sv
tb/sv/phash_dct_32x32_low8x8_core_test.sv
